FILE: rtl/core/stcp_pkg.sv
// Package for the servo target command parser: item and result structs,
// operation, event, zone and parse phase codes, and the deadband helper.
// No dependencies.
package stcp_pkg;

  // Input item
  typedef struct packed {
    logic [1:0] op;
    logic [7:0] rx_byte;
    logic [7:0] query_channel;
  } cmd_t;

  // Result item
  typedef struct packed {
    logic [1:0]  event_res;
    logic [7:0]  channel;
    logic [14:0] pulse;
    logic        armed;
    logic [1:0]  zone;
  } res_t;

  // Operation codes
  localparam logic [1:0] OP_BYTE  = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_QUERY = 2'd2;

  // Event codes
  localparam logic [1:0] EV_NONE   = 2'd0;
  localparam logic [1:0] EV_STORED = 2'd1;
  localparam logic [1:0] EV_BAD_CH = 2'd2;
  localparam logic [1:0] EV_ANSWER = 2'd3;

  // Zone codes
  localparam logic [1:0] ZONE_DEAD = 2'd0;
  localparam logic [1:0] ZONE_FWD  = 2'd1;
  localparam logic [1:0] ZONE_REV  = 2'd2;

  // Parse phases
  localparam logic [1:0] PH_CMD  = 2'd0;
  localparam logic [1:0] PH_CHAN = 2'd1;
  localparam logic [1:0] PH_LOW  = 2'd2;
  localparam logic [1:0] PH_HIGH = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_CHANNEL_ENABLE   = 2'd0;
  localparam logic [1:0] CFG_AUTOKILL_TICKS   = 2'd1;
  localparam logic [1:0] CFG_RESET_HOLD_TICKS = 2'd2;

  // Protocol bytes and pulse constants
  localparam logic [7:0]  SYNC_BYTE       = 8'hAA;
  localparam logic [7:0]  CMD_SET_TARGET  = 8'h84;
  localparam logic [6:0]  LOW_MASK        = 7'h7F;
  localparam logic [14:0] NEUTRAL_PULSE   = 15'd6000;
  localparam logic [12:0] FWD_LIMIT       = 13'd1525;
  localparam logic [12:0] REV_LIMIT       = 13'd1475;
  localparam int          MAX_HW_CHANNELS = 24;

  localparam logic [23:0] ENABLE_RESET     = 24'd0;
  localparam logic [31:0] AUTOKILL_RESET   = 32'd1000;
  localparam logic [31:0] RESET_HOLD_RESET = 32'd155000;

  // Deadband zone of a pulse in quarter microseconds
  function automatic logic [1:0] zone_of(input logic [14:0] pulse);
    logic [12:0] us;
    us = pulse[14:2];
    if (us > FWD_LIMIT) begin
      return ZONE_FWD;
    end else if (us < REV_LIMIT) begin
      return ZONE_REV;
    end else begin
      return ZONE_DEAD;
    end
  endfunction

endpackage

FILE: rtl/core/servo_target_command_parser.sv
// Servo target command parser: serial set-target decoder, tick counter and
// per-channel pulse/deadline cells. Depends on stcp_pkg.
// The result of an item sits in the result register the cycle after the
// item is accepted. Throughput: one item per cycle, held only by a stalled
// result register (cmd_ready follows res_ready).
// Reset (synchronous, rst high): unsynced, time 0, pulses 6000, deadlines 0.
module servo_target_command_parser #(
  parameter int CHANNELS = 24
) (
  input  logic            clk,
  input  logic            rst,
  // Input items
  input  logic            cmd_valid,
  output logic            cmd_ready,
  input  stcp_pkg::cmd_t  cmd,
  // Result items
  output logic            res_valid,
  input  logic            res_ready,
  output stcp_pkg::res_t  res,
  // Configuration writes
  input  logic            cfg_wr_en,
  input  logic [1:0]      cfg_index,
  input  logic [31:0]     cfg_data
);

  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Configuration registers
  logic [23:0] channel_enable;
  logic [31:0] autokill_ticks;
  logic [31:0] reset_hold_ticks;

  // Parser state
  logic        synced, synced_next;
  logic [1:0]  phase, phase_next;
  logic [7:0]  pending_channel, pending_channel_next;
  logic [6:0]  pending_low_bits, pending_low_bits_next;
  logic [47:0] time_now, time_now_next;

  // Channel cells: each holds its pulse and two deadlines, and compares its
  // own deadlines against the shared time counter every cycle.
  logic [14:0] pulse_store       [CHANNELS];
  logic [47:0] autokill_deadline [CHANNELS];
  logic [47:0] armed_deadline    [CHANNELS];
  logic [CHANNELS-1:0] armed_now;
  logic [CHANNELS-1:0] expired_now;

  // Cell write controls
  logic          wr_pulse, wr_autokill, wr_armed;
  logic [CW-1:0] wr_idx;
  logic [14:0]   wr_pulse_val;

  logic          accept;
  logic          res_valid_next;
  stcp_pkg::res_t res_next;

  logic [31:0]   enable_ext;
  logic [CW-1:0] cmd_idx, query_idx;
  logic          byte_ch_ok, query_ch_ok, pending_in_range;
  logic [14:0]   new_pulse;
  logic [47:0]   autokill_sum, hold_sum;
  logic          cmd_arm;
  logic [14:0]   query_pulse;

  // An item moves in whenever the result register is empty or being drained
  assign cmd_ready = !res_valid || res_ready;
  assign accept    = cmd_valid && cmd_ready;

  assign enable_ext = {8'd0, channel_enable};
  assign cmd_idx    = pending_channel[CW-1:0];
  assign query_idx  = cmd.query_channel[CW-1:0];

  // A channel is usable when it exists in the cell row, lies below the
  // hardware limit of 24 and has its enable bit set.
  assign byte_ch_ok = ({1'b0, cmd.rx_byte} < 9'(CHANNELS))
                   && ({1'b0, cmd.rx_byte} < 9'(stcp_pkg::MAX_HW_CHANNELS))
                   && enable_ext[cmd.rx_byte[4:0]];
  assign query_ch_ok = ({1'b0, cmd.query_channel} < 9'(CHANNELS))
                    && ({1'b0, cmd.query_channel} < 9'(stcp_pkg::MAX_HW_CHANNELS))
                    && enable_ext[cmd.query_channel[4:0]];
  assign pending_in_range = ({1'b0, pending_channel} < 9'(CHANNELS));

  // Width from the pending low seven bits and the high byte shifted by seven
  assign new_pulse    = {cmd.rx_byte, pending_low_bits};
  assign autokill_sum = time_now + {16'd0, autokill_ticks};
  assign hold_sum     = time_now + {16'd0, reset_hold_ticks};

  // A neutral command re-arms the channel in the same step, so take the
  // fresh deadline rather than the stored one.
  assign cmd_arm = (new_pulse == stcp_pkg::NEUTRAL_PULSE) ? (time_now <= hold_sum)
                                                          : armed_now[cmd_idx];

  assign query_pulse = pulse_store[query_idx];

  // Per-cell deadline compares
  always_comb begin
    for (int i = 0; i < CHANNELS; i++) begin
      armed_now[i]   = (time_now <= armed_deadline[i]);
      expired_now[i] = (time_now > autokill_deadline[i]);
    end
  end

  // Item decode and next state
  always_comb begin
    synced_next           = synced;
    phase_next            = phase;
    pending_channel_next  = pending_channel;
    pending_low_bits_next = pending_low_bits;
    time_now_next         = time_now;
    wr_pulse              = 1'b0;
    wr_autokill           = 1'b0;
    wr_armed              = 1'b0;
    wr_idx                = cmd_idx;
    wr_pulse_val          = new_pulse;
    res_next              = '0;
    if (accept) begin
      case (cmd.op)
        stcp_pkg::OP_TICK: begin
          time_now_next = time_now + 48'd1;
        end
        stcp_pkg::OP_BYTE: begin
          if (!synced) begin
            // Drop everything until the sync byte
            if (cmd.rx_byte == stcp_pkg::SYNC_BYTE) begin
              synced_next = 1'b1;
              phase_next  = stcp_pkg::PH_CMD;
            end
          end else begin
            unique case (phase)
              stcp_pkg::PH_CMD: begin
                if (cmd.rx_byte == stcp_pkg::CMD_SET_TARGET) begin
                  phase_next = stcp_pkg::PH_CHAN;
                end
              end
              stcp_pkg::PH_CHAN: begin
                if (byte_ch_ok) begin
                  pending_channel_next = cmd.rx_byte;
                  phase_next           = stcp_pkg::PH_LOW;
                end else begin
                  // Report the bad channel and go back to waiting
                  phase_next         = stcp_pkg::PH_CMD;
                  res_next.event_res = stcp_pkg::EV_BAD_CH;
                  res_next.channel   = cmd.rx_byte;
                end
              end
              stcp_pkg::PH_LOW: begin
                pending_low_bits_next = cmd.rx_byte[6:0] & stcp_pkg::LOW_MASK;
                phase_next            = stcp_pkg::PH_HIGH;
              end
              stcp_pkg::PH_HIGH: begin
                phase_next = stcp_pkg::PH_CMD;
                if (pending_in_range) begin
                  wr_pulse    = 1'b1;
                  wr_autokill = 1'b1;
                  wr_armed    = (new_pulse == stcp_pkg::NEUTRAL_PULSE);
                  res_next.event_res = stcp_pkg::EV_STORED;
                  res_next.channel   = pending_channel;
                  res_next.pulse     = new_pulse;
                  res_next.armed     = cmd_arm;
                  res_next.zone      = cmd_arm ? stcp_pkg::zone_of(new_pulse)
                                               : stcp_pkg::ZONE_DEAD;
                end
              end
              default: ;
            endcase
          end
        end
        stcp_pkg::OP_QUERY: begin
          res_next.channel = cmd.query_channel;
          if (!query_ch_ok) begin
            res_next.event_res = stcp_pkg::EV_BAD_CH;
          end else if (!armed_now[query_idx]) begin
            // Disarmed: report the stored pulse, no autokill write-back
            res_next.event_res = stcp_pkg::EV_ANSWER;
            res_next.pulse     = query_pulse;
          end else begin
            res_next.event_res = stcp_pkg::EV_ANSWER;
            res_next.armed     = 1'b1;
            if (expired_now[query_idx]) begin
              // Autokill passed: fall back to neutral and write it back
              wr_pulse       = 1'b1;
              wr_idx         = query_idx;
              wr_pulse_val   = stcp_pkg::NEUTRAL_PULSE;
              res_next.pulse = stcp_pkg::NEUTRAL_PULSE;
              res_next.zone  = stcp_pkg::zone_of(stcp_pkg::NEUTRAL_PULSE);
            end else begin
              res_next.pulse = query_pulse;
              res_next.zone  = stcp_pkg::zone_of(query_pulse);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Hold a result until it is taken; a new one may replace it the same cycle
  assign res_valid_next = accept || (res_valid && !res_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_enable   <= stcp_pkg::ENABLE_RESET;
      autokill_ticks   <= stcp_pkg::AUTOKILL_RESET;
      reset_hold_ticks <= stcp_pkg::RESET_HOLD_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        stcp_pkg::CFG_CHANNEL_ENABLE:   channel_enable   <= cfg_data[23:0];
        stcp_pkg::CFG_AUTOKILL_TICKS:   autokill_ticks   <= cfg_data;
        stcp_pkg::CFG_RESET_HOLD_TICKS: reset_hold_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      synced           <= 1'b0;
      phase            <= stcp_pkg::PH_CMD;
      pending_channel  <= 8'd0;
      pending_low_bits <= 7'd0;
      time_now         <= 48'd0;
      res_valid        <= 1'b0;
    end else begin
      synced           <= synced_next;
      phase            <= phase_next;
      pending_channel  <= pending_channel_next;
      pending_low_bits <= pending_low_bits_next;
      time_now         <= time_now_next;
      res_valid        <= res_valid_next;
    end
  end

  // Result payload: no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

  // Channel cells
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        pulse_store[i]       <= stcp_pkg::NEUTRAL_PULSE;
        autokill_deadline[i] <= 48'd0;
        armed_deadline[i]    <= 48'd0;
      end
    end else begin
      if (wr_pulse) begin
        pulse_store[wr_idx] <= wr_pulse_val;
      end
      if (wr_autokill) begin
        autokill_deadline[wr_idx] <= autokill_sum;
      end
      if (wr_armed) begin
        armed_deadline[wr_idx] <= hold_sum;
      end
    end
  end

  // Every accepted item leaves a result behind
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> res_valid)
    else $error("accepted item left no result");

  // A tick advances time by exactly one
  a_tick_advances: assert property (@(posedge clk) disable iff (rst)
    accept && cmd.op == stcp_pkg::OP_TICK |=> time_now == $past(time_now) + 48'd1)
    else $error("tick did not advance time");

  // A disarmed answer never carries a zone
  a_disarmed_zone: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.armed |-> res.zone == stcp_pkg::ZONE_DEAD)
    else $error("zone reported while disarmed");

  // Before sync the parser stays at the command phase
  a_unsynced_phase: assert property (@(posedge clk) disable iff (rst)
    !synced |-> phase == stcp_pkg::PH_CMD)
    else $error("parse phase moved before sync");

endmodule
